// ===== design/serial_frame_parser_sum_check_defines.svh =====
// Assertion macros used by the checker of the frame parser.
`ifndef SERIAL_FRAME_PARSER_SUM_CHECK_DEFINES_SVH
`define SERIAL_FRAME_PARSER_SUM_CHECK_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SFP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sfp_pkg.sv =====
// Package of constants and controller/datapath interface types for the frame parser.
package sfp_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int IDX_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;

   typedef struct packed {
      logic sum_init;
      logic take_id;
      logic take_cmd;
      logic take_len;
      logic take_data;
      logic drain_start;
      logic drain_load;
   } sfp_cmd_type;

   typedef struct packed {
      logic hdr_match;
      logic len_is_zero;
      logic data_done;
      logic sum_ok;
      logic drain_last;
      logic out_free;
   } sfp_status_type;

endpackage

// ===== design/sfp_ctrl.sv =====
// Controller state machine of the frame parser: frame phases and result drain.
module sfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sfp_pkg::sfp_status_type status,
   output sfp_pkg::sfp_cmd_type    cmd
);

   localparam logic [2:0] ST_HEADER = 3'd0;
   localparam logic [2:0] ST_ID     = 3'd1;
   localparam logic [2:0] ST_CMD    = 3'd2;
   localparam logic [2:0] ST_LEN    = 3'd3;
   localparam logic [2:0] ST_DATA   = 3'd4;
   localparam logic [2:0] ST_SUM    = 3'd5;
   localparam logic [2:0] ST_DRAIN  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_stall = (state_ff == ST_DRAIN);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_ID: begin
            if (accept) begin
               cmd.take_id = 1'b1;
               state_in    = ST_CMD;
            end
         end
         ST_CMD: begin
            if (accept) begin
               cmd.take_cmd = 1'b1;
               state_in     = ST_LEN;
            end
         end
         ST_LEN: begin
            if (accept) begin
               cmd.take_len = 1'b1;
               state_in     = status.len_is_zero ? ST_SUM : ST_DATA;
            end
         end
         ST_DATA: begin
            if (accept) begin
               cmd.take_data = 1'b1;
               if (status.data_done) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (accept) begin
               if (status.sum_ok) begin
                  cmd.drain_start = 1'b1;
                  state_in        = ST_DRAIN;
               end else begin
                  state_in = ST_HEADER;
               end
            end
         end
         ST_DRAIN: begin
            // One result goes to the output register whenever it has room.
            if (status.out_free) begin
               cmd.drain_load = 1'b1;
               if (status.drain_last) begin
                  state_in = ST_HEADER;
               end
            end
         end
         default: begin
            if (accept && status.hdr_match) begin
               cmd.sum_init = 1'b1;
               state_in     = ST_ID;
            end else begin
               state_in = ST_HEADER;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEADER;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/sfp_dp.sv =====
// Datapath of the frame parser: held fields, checksum, payload store and output register.
module sfp_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sfp_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic                          csr_wr_en,
   input  logic [sfp_pkg::BYTE_W-1:0]    csr_wr_data,
   input  sfp_pkg::sfp_cmd_type          cmd,
   output sfp_pkg::sfp_status_type       status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_frame_id,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_frame_cmd,
   output logic [sfp_pkg::LEN_W-1:0]     rsp_frame_len,
   output logic [sfp_pkg::IDX_W-1:0]     rsp_byte_index,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                          rsp_last_of_frame
);

   logic [sfp_pkg::BYTE_W-1:0] header_ff;
   logic [sfp_pkg::BYTE_W-1:0] held_id_ff;
   logic [sfp_pkg::BYTE_W-1:0] held_cmd_ff;
   logic [sfp_pkg::BYTE_W-1:0] held_len_ff;
   logic [sfp_pkg::BYTE_W-1:0] byte_count_ff;
   logic [sfp_pkg::BYTE_W-1:0] sum_ff;
   logic [sfp_pkg::BYTE_W-1:0] sum_in;
   logic                       too_long_ff;
   logic [sfp_pkg::IDX_W-1:0]  rd_idx_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [sfp_pkg::BYTE_W-1:0] rsp_id_ff;
   logic [sfp_pkg::BYTE_W-1:0] rsp_cmd_ff;
   logic [sfp_pkg::LEN_W-1:0]  rsp_len_ff;
   logic [sfp_pkg::IDX_W-1:0]  rsp_idx_ff;
   logic [sfp_pkg::BYTE_W-1:0] rsp_data_ff;
   logic                       rsp_last_ff;
   logic                       store_wr;
   logic                       len_zero;
   logic                       drain_last;

   logic [sfp_pkg::BYTE_W-1:0] store_mem [sfp_pkg::MAX_PAYLOAD];

   assign len_zero = (held_len_ff == '0);
   assign drain_last = len_zero ||
      (({1'b0, rd_idx_ff} + sfp_pkg::LEN_W'(1)) == held_len_ff[sfp_pkg::LEN_W-1:0]);
   assign store_wr = cmd.take_data && !too_long_ff &&
      (byte_count_ff < sfp_pkg::BYTE_W'(sfp_pkg::MAX_PAYLOAD));

   assign sum_in = cmd.sum_init ? req_rx_byte : sum_ff + req_rx_byte;

   always_comb begin
      status.hdr_match   = (req_rx_byte == header_ff);
      status.len_is_zero = (req_rx_byte == '0);
      status.data_done   = ({1'b0, byte_count_ff} + 9'd1) >= {1'b0, held_len_ff};
      status.sum_ok      = (req_rx_byte == sum_ff) && !too_long_ff;
      status.drain_last  = drain_last;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid_in = cmd.drain_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff     <= 8'hFF;
         held_id_ff    <= '0;
         held_cmd_ff   <= '0;
         held_len_ff   <= '0;
         byte_count_ff <= '0;
         sum_ff        <= '0;
         too_long_ff   <= 1'b0;
         rd_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            header_ff <= csr_wr_data;
         end
         if (cmd.sum_init || cmd.take_id || cmd.take_cmd || cmd.take_len || cmd.take_data) begin
            sum_ff <= sum_in;
         end
         if (cmd.take_id) begin
            held_id_ff <= req_rx_byte;
         end
         if (cmd.take_cmd) begin
            held_cmd_ff <= req_rx_byte;
         end
         if (cmd.take_len) begin
            held_len_ff   <= req_rx_byte;
            byte_count_ff <= '0;
            too_long_ff   <= (req_rx_byte > sfp_pkg::BYTE_W'(sfp_pkg::MAX_PAYLOAD));
         end
         if (cmd.take_data) begin
            byte_count_ff <= byte_count_ff + 8'd1;
         end
         if (cmd.drain_start) begin
            rd_idx_ff <= '0;
         end else if (cmd.drain_load) begin
            rd_idx_ff <= rd_idx_ff + sfp_pkg::IDX_W'(1);
         end
      end
   end

   // Payload store: written during the data phase, read into the output register.
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[byte_count_ff[sfp_pkg::IDX_W-1:0]] <= req_rx_byte;
      end
      if (cmd.drain_load) begin
         rsp_id_ff   <= held_id_ff;
         rsp_cmd_ff  <= held_cmd_ff;
         rsp_len_ff  <= held_len_ff[sfp_pkg::LEN_W-1:0];
         rsp_idx_ff  <= rd_idx_ff;
         rsp_last_ff <= drain_last;
         if (len_zero) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= store_mem[rd_idx_ff];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_id      = rsp_id_ff;
   assign rsp_frame_cmd     = rsp_cmd_ff;
   assign rsp_frame_len     = rsp_len_ff;
   assign rsp_byte_index    = rsp_idx_ff;
   assign rsp_payload_byte  = rsp_data_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

// ===== design/serial_frame_parser_sum_check.sv =====
// Top level of the serial frame parser with additive checksum.
//
// The req_ channel takes one received byte per word (req_rx_byte). Bytes are
// parsed as header, id, command, length, payload and checksum; bytes before a
// header equal to the configured value are skipped. The csr_ port writes the
// header value (reset value 0xFF); the user must write it only while the block
// is idle, which the block itself does not enforce. While a frame is being
// parsed, one input word is accepted per cycle. When the checksum byte matches,
// the frame is sent on the rsp_ channel as one word per payload byte (one word
// with zero data for an empty payload), the final word marked by
// rsp_last_of_frame. The first result is loaded into the output register once
// the parser is in the drain state after the checksum word is accepted, then
// one per cycle while the receiver does not stall. During the drain req_stall
// is high; input is taken again once the last result is in the output
// register. Frames with a bad checksum or a length above the store size are
// dropped without any output.
// Synchronous reset returns the parser to waiting for a header and empties the
// output register; the payload store is not cleared.
module serial_frame_parser_sum_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sfp_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic                          csr_wr_en,
   input  logic [sfp_pkg::BYTE_W-1:0]    csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_frame_id,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_frame_cmd,
   output logic [sfp_pkg::LEN_W-1:0]     rsp_frame_len,
   output logic [sfp_pkg::IDX_W-1:0]     rsp_byte_index,
   output logic [sfp_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                          rsp_last_of_frame
);

   sfp_pkg::sfp_cmd_type    cmd;
   sfp_pkg::sfp_status_type status;

   sfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_id      (rsp_frame_id),
      .rsp_frame_cmd     (rsp_frame_cmd),
      .rsp_frame_len     (rsp_frame_len),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

// ===== design/serial_frame_parser_sum_check_checker.sv =====
// Port-level checker for the frame parser, bound to the top level.
`include "serial_frame_parser_sum_check_defines.svh"

module sfp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [sfp_pkg::BYTE_W-1:0]    rsp_payload_byte,
   input logic [sfp_pkg::IDX_W-1:0]     rsp_byte_index,
   input logic                          rsp_last_of_frame
);

   // A stalled result word must hold.
   `SFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_byte_index) && $stable(rsp_last_of_frame), "stalled result changed")

   // The drain follows a taken word with the next index at once.
   `SFP_ASSERT_NEXT(a_drain_next, clock, reset, rsp_valid && !rsp_stall && !rsp_last_of_frame, rsp_valid && (rsp_byte_index == sfp_pkg::IDX_W'($past(rsp_byte_index) + 1'b1)), "drain skipped an index")

   // No input is taken while a frame is still being sent.
   `SFP_ASSERT_NOW(a_stall_in_drain, clock, reset, rsp_valid && !rsp_last_of_frame, req_stall, "input taken during drain")

endmodule

bind serial_frame_parser_sum_check sfp_checker u_sfp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_byte_index    (rsp_byte_index),
   .rsp_last_of_frame (rsp_last_of_frame)
);

// ===== sim/serial_frame_parser_sum_check_test.sv =====
// Self-checking testbench for the serial frame parser with additive checksum.
module serial_frame_parser_sum_check_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 80;

   typedef enum logic [2:0] {
      WAIT_HEADER, TAKE_ID, TAKE_CMD, TAKE_LEN, TAKE_DATA, TAKE_SUM
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] frame_id;
      logic [7:0] frame_cmd;
      logic [6:0] frame_len;
      logic [5:0] byte_index;
      logic [7:0] payload_byte;
      logic       last_of_frame;
   } frame_word_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [sfp_pkg::BYTE_W-1:0] req_rx_byte;
   logic                      csr_wr_en;
   logic [sfp_pkg::BYTE_W-1:0] csr_wr_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [sfp_pkg::BYTE_W-1:0] rsp_frame_id;
   logic [sfp_pkg::BYTE_W-1:0] rsp_frame_cmd;
   logic [sfp_pkg::LEN_W-1:0]  rsp_frame_len;
   logic [sfp_pkg::IDX_W-1:0]  rsp_byte_index;
   logic [sfp_pkg::BYTE_W-1:0] rsp_payload_byte;
   logic                      rsp_last_of_frame;

   serial_frame_parser_sum_check dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_id      (rsp_frame_id),
      .rsp_frame_cmd     (rsp_frame_cmd),
      .rsp_frame_len     (rsp_frame_len),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // Parser shadow state.
   logic [7:0]      header_value = 8'hFF;
   parse_phase_type phase        = WAIT_HEADER;
   logic [7:0]      held_id      = '0;
   logic [7:0]      held_cmd     = '0;
   logic [7:0]      held_len     = '0;
   logic [7:0]      byte_count   = '0;
   logic [7:0]      running_sum  = '0;
   logic            too_long     = 1'b0;
   logic [7:0]      payload_store [sfp_pkg::MAX_PAYLOAD];

   frame_word_type  expected_words [$];
   logic [7:0]      pending_bytes [$];
   int              error_count  = 0;
   int              cycle_count  = 0;
   int              send_gap     = 0;
   int              stall_left   = 0;
   bit              word_taken   = 1'b0;
   bit              idle_on      = 1'b1;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (!idle_on || r < 9) return 0;
      if (r < 14) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Advances the shadow parser by one received byte and queues any frame words due.
   task automatic parse_rx_byte(input logic [7:0] b);
      frame_word_type w;
      case (phase)
         TAKE_ID: begin
            held_id = b;
            running_sum += b;
            phase = TAKE_CMD;
         end
         TAKE_CMD: begin
            held_cmd = b;
            running_sum += b;
            phase = TAKE_LEN;
         end
         TAKE_LEN: begin
            held_len = b;
            running_sum += b;
            byte_count = '0;
            too_long = (b > sfp_pkg::MAX_PAYLOAD);
            phase = (b == 8'd0) ? TAKE_SUM : TAKE_DATA;
         end
         TAKE_DATA: begin
            if (!too_long && byte_count < sfp_pkg::MAX_PAYLOAD)
               payload_store[byte_count[5:0]] = b;
            running_sum += b;
            byte_count += 8'd1;
            if (byte_count >= held_len) phase = TAKE_SUM;
         end
         TAKE_SUM: begin
            if (b == running_sum && !too_long) begin
               w.frame_id  = held_id;
               w.frame_cmd = held_cmd;
               w.frame_len = held_len[6:0];
               if (held_len == 8'd0) begin
                  w.byte_index    = '0;
                  w.payload_byte  = '0;
                  w.last_of_frame = 1'b1;
                  expected_words.push_back(w);
               end else begin
                  for (int i = 0; i < held_len; i++) begin
                     w.byte_index    = i[5:0];
                     w.payload_byte  = payload_store[i[5:0]];
                     w.last_of_frame = (i + 1 == held_len);
                     expected_words.push_back(w);
                  end
               end
            end
            phase = WAIT_HEADER;
         end
         default: begin
            if (b == header_value) begin
               running_sum = b;
               phase = TAKE_ID;
            end else begin
               phase = WAIT_HEADER;
            end
         end
      endcase
   endtask

   // Input acceptance, register shadowing and result checking.
   always @(posedge clock) begin
      frame_word_type want;
      word_taken = 1'b0;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("serial_frame_parser_sum_check_test: done, errors");
         $finish;
      end else if (!reset) begin
         if (csr_wr_en) header_value = csr_wr_data;
         if (req_valid && !req_stall) begin
            word_taken = 1'b1;
            parse_rx_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: id 0x%0h index %0d", rsp_frame_id,
                      rsp_byte_index);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("frame_id", 32'(want.frame_id), 32'(rsp_frame_id));
               check_field("frame_cmd", 32'(want.frame_cmd), 32'(rsp_frame_cmd));
               check_field("frame_len", 32'(want.frame_len), 32'(rsp_frame_len));
               check_field("byte_index", 32'(want.byte_index), 32'(rsp_byte_index));
               check_field("payload_byte", 32'(want.payload_byte),
                           32'(rsp_payload_byte));
               check_field("last_of_frame", 32'(want.last_of_frame),
                           32'(rsp_last_of_frame));
            end
         end
      end
   end

   // Sender: a held word stays put until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (pending_bytes.size() > 0) begin
         req_valid   <= 1'b1;
         req_rx_byte <= pending_bytes.pop_front();
         send_gap = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Queues one frame; fill below zero gives random payload bytes.
   task automatic queue_frame(input logic [7:0] hdr, input logic [7:0] id,
                              input logic [7:0] cmd, input logic [7:0] len,
                              input int fill, input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] d;
      sum = hdr + id + cmd + len;
      pending_bytes.push_back(hdr);
      pending_bytes.push_back(id);
      pending_bytes.push_back(cmd);
      pending_bytes.push_back(len);
      for (int i = 0; i < len; i++) begin
         d = (fill < 0) ? 8'($urandom) : fill[7:0];
         pending_bytes.push_back(d);
         sum += d;
      end
      if (bad_sum) sum += 8'($urandom_range(1, 255));
      pending_bytes.push_back(sum);
   endtask

   // Mostly well-formed frames with small payloads, mixed with noise and broken frames.
   task automatic queue_random_traffic(input int n_bytes, input logic [7:0] hdr);
      int queued;
      int r;
      int n;
      queued = 0;
      while (queued < n_bytes) begin
         n = pending_bytes.size();
         r = $urandom_range(0, 19);
         if (r < 2) begin
            repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom));
         end else if (r == 2) begin
            queue_frame(hdr, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)), -1,
                        1'b1);
         end else if (r == 3) begin
            queue_frame(hdr, 8'($urandom), 8'($urandom), 8'($urandom_range(65, 70)), -1,
                        1'b0);
         end else if (r == 4) begin
            queue_frame(hdr, 8'($urandom), 8'($urandom), 8'd64, -1, 1'b0);
         end else if (r == 5) begin
            // Frame cut short: the next frame's bytes land in its fields.
            pending_bytes.push_back(hdr);
            repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom));
         end else begin
            queue_frame(hdr, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)), -1,
                        1'b0);
         end
         queued += pending_bytes.size() - n;
      end
   endtask

   // Waits until every queued word is taken and every expected result has come.
   task automatic wait_until_drained();
      int waited;
      waited = 0;
      while ((pending_bytes.size() != 0 || req_valid || expected_words.size() != 0)
             && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      if (expected_words.size() != 0) begin
         $error("%0d expected result words never arrived", expected_words.size());
         error_count++;
         expected_words.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_header(input logic [7:0] value);
      wait_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [7:0] hdr;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      rsp_stall   <= 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: noise, empty payload, header value inside data, bad checksum, one byte.
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'h7F);
      queue_frame(8'hFF, 8'h00, 8'hFF, 8'd0, -1, 1'b0);
      queue_frame(8'hFF, 8'hFF, 8'h00, 8'd2, 255, 1'b0);
      queue_frame(8'hFF, 8'h5A, 8'hA5, 8'd0, -1, 1'b1);
      queue_frame(8'hFF, 8'h80, 8'h01, 8'd1, 0, 1'b0);

      write_header(8'h00);
      queue_random_traffic(30, 8'h00);

      hdr = 8'($urandom_range(1, 254));
      write_header(hdr);
      idle_on = 1'b0;
      queue_random_traffic(30, hdr);

      write_header(8'hFF);
      idle_on = 1'b1;
      // Largest payload and one past it.
      queue_frame(8'hFF, 8'($urandom), 8'($urandom), 8'd64, -1, 1'b0);
      queue_frame(8'hFF, 8'($urandom), 8'($urandom), 8'd65, -1, 1'b0);
      queue_random_traffic(30, 8'hFF);

      wait_until_drained();
      if (error_count == 0)
         $display("serial_frame_parser_sum_check_test: done, clean");
      else
         $display("serial_frame_parser_sum_check_test: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/sfp_pkg.sv
design/sfp_ctrl.sv
design/sfp_dp.sv
design/serial_frame_parser_sum_check.sv
design/serial_frame_parser_sum_check_checker.sv
sim/serial_frame_parser_sum_check_test.sv
